/* src/smhs_pkg.sv */
// shared types and constants for the stepper move and home sequencer
`default_nettype none

package smhs_pkg;

    // command codes carried in the input tuser
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_MOVE  = 2'd1;
    localparam logic [1:0] CMD_HOME  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_TOTAL_STEPS      = 3'd0;
    localparam logic [2:0] REG_SLOW_ZONE        = 3'd1;
    localparam logic [2:0] REG_SLOW_HALF_PERIOD = 3'd2;
    localparam logic [2:0] REG_FAST_HALF_PERIOD = 3'd3;
    localparam logic [2:0] REG_DEBOUNCE_TICKS   = 3'd4;

    // configuration reset values
    localparam logic [15:0] TOTAL_STEPS_RST      = 16'd8000;
    localparam logic [15:0] SLOW_ZONE_RST        = 16'd400;
    localparam logic [7:0]  SLOW_HALF_PERIOD_RST = 8'd2;
    localparam logic [7:0]  FAST_HALF_PERIOD_RST = 8'd1;
    localparam logic [7:0]  DEBOUNCE_TICKS_RST   = 8'd20;

    // reciprocal of five for a 16 bit dividend, scaled by 2^18
    localparam logic [31:0] RECIP5_16 = 32'h0000_CCCD;
    localparam int          RECIP5_SHIFT = 18;

    // widths of the stream payloads
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] step_count;
        logic        direction;
        logic        origin_sensor;
        logic        overtravel_n;
    } item_t;

    typedef struct packed {
        logic        pulse;
        logic        dir_level;
        logic        enable_n;
        logic [15:0] display_count;
        logic        busy_res;
        logic        homed;
    } result_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  index;
        logic [15:0] data;
    } cfg_wr_t;

endpackage

`default_nettype wire

/* src/stepper_move_and_home_sequencer_top.sv */
// top level of the stepper move and home sequencer
// Each input transaction is a timer tick or a command; the block returns exactly one result
// transaction for it. One transaction is taken every clock cycle when the sink keeps up; a
// result passes through the input register and then the result register, and the motion
// state registers are updated in a single pass in between.
// Configuration writes are taken at once (cfg_ready is always high) and should be made
// while no transaction is in flight.
`default_nettype none

module stepper_move_and_home_sequencer_top
    import smhs_pkg::*;
#(
    parameter int STEP_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [15:0] step_count, [16] direction, [17] origin_sensor, [18] overtravel_n, rest zero
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] command
    input  wire logic [1:0]            s_tuser,
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [0] pulse, [1] dir_level, [2] enable_n, [18:3] display_count, [19] busy_res,
    // [20] homed, rest zero
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [15:0]           cfg_data
);

    logic    item_valid;
    item_t   item;
    logic    space;
    logic    fire;
    result_t result;
    cfg_wr_t cfg_wr;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    // an item moves on when the result register can take its result
    assign fire = item_valid && space;

    // input register
    smhs_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    // state update
    smhs_core #(
        .STEP_BITS (STEP_BITS)
    ) u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg_wr),
        .fire   (fire),
        .item   (item),
        .result (result)
    );

    // result register
    smhs_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .result   (result),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef ASSERT_OFF
    // a held item is never dropped before it is processed
    a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !fire |=> item_valid)
        else $error("input item lost before processing");

    // every processed item shows up in the result register
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid)
        else $error("processed item gave no result");

    // homing completion leaves the block idle with a cleared display
    a_homed_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[20] |-> !m_tdata[19] && m_tdata[2] && (m_tdata[18:3] == 16'd0))
        else $error("homed flag with busy block or nonzero display");
`endif

endmodule

`default_nettype wire

/* src/smhs_in_stage.sv */
// input register stage: captures one transaction and holds it until the core takes it
`default_nettype none

module smhs_in_stage
    import smhs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic [1:0]            s_tuser,
    input  wire logic                  take,
    output logic                       item_valid,
    output item_t                      item
);

    logic  valid_reg;
    item_t item_reg;

    // free when empty or when the held item leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    // payload unpack
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.command       <= s_tuser;
            item_reg.step_count    <= s_tdata[15:0];
            item_reg.direction     <= s_tdata[16];
            item_reg.origin_sensor <= s_tdata[17];
            item_reg.overtravel_n  <= s_tdata[18];
        end
    end

endmodule

`default_nettype wire

/* src/smhs_core.sv */
// sequencer core: configuration registers, motion state and the per-item update
`default_nettype none

module smhs_core
    import smhs_pkg::*;
#(
    parameter int STEP_BITS = 16
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_wr_t cfg_wr,
    input  wire logic    fire,
    input  wire item_t   item,
    output result_t      result
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_MOVE,
        MODE_OT_WAIT,
        MODE_HOME_WAIT,
        MODE_HOMING
    } mode_t;

    localparam int CW = STEP_BITS + 17;

    // configuration registers
    logic [15:0] total_steps_reg;
    logic [15:0] slow_zone_reg;
    logic [7:0]  slow_half_reg;
    logic [7:0]  fast_half_reg;
    logic [7:0]  debounce_reg;

    // motion state
    mode_t                mode_reg, mode_next;
    logic [STEP_BITS-1:0] remaining_reg, remaining_next;
    logic [2:0]           rem_mod5_reg, rem_mod5_next;
    logic [7:0]           tick_reg, tick_next;
    logic                 phase_reg, phase_next;
    logic                 pulse_reg, pulse_next;
    logic [STEP_BITS-1:0] progress_reg, progress_next;
    logic                 forward_reg, forward_next;
    logic [15:0]          disp_reg, disp_next;
    logic                 homed_next;

    // helper terms
    logic [STEP_BITS+15:0] load_ext;
    logic [STEP_BITS-1:0]  load_rem;
    logic [STEP_BITS+31:0] load_wide;
    logic [2:0]            load_mod5;
    logic [CW-1:0]         rem_ext, zone_ext, total_ext;
    logic                  slow;
    logic [7:0]            limit;
    logic [7:0]            tick_inc;
    logic                  hold_done;
    logic [31:0]           total_prod;
    logic [15:0]           total_div5;
    logic [STEP_BITS-1:0]  progress_inc;
    logic [STEP_BITS+15:0] progress_ext;
    logic [15:0]           progress_lo;
    logic [2:0]            mod5_dec;

    // residue modulo five of a 32 bit value: nibble sum, then a reciprocal step
    function automatic logic [2:0] mod5_32(input logic [31:0] x);
        logic [6:0]  s;
        logic [14:0] p;
        logic [4:0]  q;
        logic [6:0]  r;
        s = 7'd0;
        for (int i = 0; i < 8; i++)
        begin
            s = s + {3'd0, x[4*i +: 4]};
        end
        p = 15'(s) * 15'd205;
        q = p[14:10];
        r = s - 7'(q) * 7'd5;
        return r[2:0];
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_steps_reg <= TOTAL_STEPS_RST;
            slow_zone_reg   <= SLOW_ZONE_RST;
            slow_half_reg   <= SLOW_HALF_PERIOD_RST;
            fast_half_reg   <= FAST_HALF_PERIOD_RST;
            debounce_reg    <= DEBOUNCE_TICKS_RST;
        end
        else if (cfg_wr.valid)
        begin
            case (cfg_wr.index)
                REG_TOTAL_STEPS:      total_steps_reg <= cfg_wr.data;
                REG_SLOW_ZONE:        slow_zone_reg   <= cfg_wr.data;
                REG_SLOW_HALF_PERIOD: slow_half_reg   <= cfg_wr.data[7:0];
                REG_FAST_HALF_PERIOD: fast_half_reg   <= cfg_wr.data[7:0];
                REG_DEBOUNCE_TICKS:   debounce_reg    <= cfg_wr.data[7:0];
                default:              ;
            endcase
        end
    end

    // step count load, truncated to the counter width
    assign load_ext  = {{STEP_BITS{1'b0}}, item.step_count - 16'd1};
    assign load_rem  = load_ext[STEP_BITS-1:0];
    assign load_wide = {32'd0, load_rem};
    assign load_mod5 = mod5_32(load_wide[31:0]);

    // slow zone test without wrap
    assign rem_ext   = {17'd0, remaining_reg};
    assign zone_ext  = {{(STEP_BITS+1){1'b0}}, slow_zone_reg};
    assign total_ext = {{(STEP_BITS+1){1'b0}}, total_steps_reg};
    assign slow      = (rem_ext < zone_ext) || ((rem_ext + zone_ext) > total_ext);

    // hold limit for the current mode
    always_comb
    begin
        case (mode_reg)
            MODE_MOVE:      limit = slow ? slow_half_reg : fast_half_reg;
            MODE_OT_WAIT:   limit = debounce_reg;
            MODE_HOME_WAIT: limit = debounce_reg;
            MODE_HOMING:    limit = slow_half_reg;
            default:        limit = slow_half_reg;
        endcase
    end

    // saturating tick counter, a zero limit acts as one tick
    assign tick_inc  = (tick_reg != 8'hFF) ? tick_reg + 8'd1 : tick_reg;
    assign hold_done = (tick_inc >= limit);

    // total_steps / 5 for the backward display
    assign total_prod = {16'd0, total_steps_reg} * RECIP5_16;
    assign total_div5 = 16'(total_prod >> RECIP5_SHIFT);

    assign progress_inc = progress_reg + 1'b1;
    assign progress_ext = {16'd0, progress_inc};
    assign progress_lo  = progress_ext[15:0];
    assign mod5_dec     = (rem_mod5_reg == 3'd0) ? 3'd4 : rem_mod5_reg - 3'd1;

    // per-item state update
    always_comb
    begin
        mode_next      = mode_reg;
        remaining_next = remaining_reg;
        rem_mod5_next  = rem_mod5_reg;
        tick_next      = tick_reg;
        phase_next     = phase_reg;
        pulse_next     = pulse_reg;
        progress_next  = progress_reg;
        forward_next   = forward_reg;
        disp_next      = disp_reg;
        homed_next     = 1'b0;

        if (mode_reg == MODE_IDLE)
        begin
            if (item.command == CMD_MOVE)
            begin
                forward_next  = item.direction;
                progress_next = '0;
                if (item.step_count != 16'd0)
                begin
                    remaining_next = load_rem;
                    rem_mod5_next  = load_mod5;
                    mode_next      = MODE_MOVE;
                    pulse_next     = !pulse_reg;
                    phase_next     = 1'b0;
                    tick_next      = 8'd0;
                end
            end
            else if (item.command == CMD_HOME)
            begin
                forward_next  = 1'b0;
                progress_next = '0;
                tick_next     = 8'd0;
                if (item.origin_sensor)
                begin
                    mode_next = MODE_HOME_WAIT;
                end
                else
                begin
                    disp_next  = 16'd0;
                    homed_next = 1'b1;
                end
            end
        end
        else if (item.command == CMD_TICK)
        begin
            tick_next = hold_done ? 8'd0 : tick_inc;
            if (hold_done)
            begin
                case (mode_reg)
                    MODE_MOVE:
                    begin
                        if (!phase_reg)
                        begin
                            pulse_next = !pulse_reg;
                            phase_next = 1'b1;
                        end
                        else
                        begin
                            // every fifth step updates the display
                            if (rem_mod5_reg == 3'd0)
                            begin
                                progress_next = progress_inc;
                                disp_next     = forward_reg ? progress_lo
                                                            : total_div5 - progress_lo;
                            end
                            if (!item.overtravel_n)
                            begin
                                mode_next = MODE_OT_WAIT;
                            end
                            else if (remaining_reg == '0)
                            begin
                                mode_next = MODE_IDLE;
                            end
                            else
                            begin
                                remaining_next = remaining_reg - 1'b1;
                                rem_mod5_next  = mod5_dec;
                                pulse_next     = !pulse_reg;
                                phase_next     = 1'b0;
                            end
                        end
                    end
                    MODE_OT_WAIT:
                    begin
                        if (!item.overtravel_n)
                        begin
                            // overtravel confirmed: turn into homing
                            forward_next  = 1'b0;
                            progress_next = '0;
                            if (item.origin_sensor)
                            begin
                                mode_next = MODE_HOME_WAIT;
                            end
                            else
                            begin
                                progress_next = '0;
                                disp_next     = 16'd0;
                                homed_next    = 1'b1;
                                mode_next     = MODE_IDLE;
                            end
                        end
                        else if (remaining_reg == '0)
                        begin
                            mode_next = MODE_IDLE;
                        end
                        else
                        begin
                            mode_next      = MODE_MOVE;
                            remaining_next = remaining_reg - 1'b1;
                            rem_mod5_next  = mod5_dec;
                            pulse_next     = !pulse_reg;
                            phase_next     = 1'b0;
                        end
                    end
                    MODE_HOME_WAIT:
                    begin
                        if (item.origin_sensor)
                        begin
                            mode_next  = MODE_HOMING;
                            pulse_next = !pulse_reg;
                            phase_next = 1'b0;
                        end
                        else
                        begin
                            progress_next = '0;
                            disp_next     = 16'd0;
                            homed_next    = 1'b1;
                            mode_next     = MODE_IDLE;
                        end
                    end
                    MODE_HOMING:
                    begin
                        if (!phase_reg)
                        begin
                            pulse_next = !pulse_reg;
                            phase_next = 1'b1;
                        end
                        else if (item.origin_sensor)
                        begin
                            progress_next = progress_inc;
                            disp_next     = progress_lo;
                            pulse_next    = !pulse_reg;
                            phase_next    = 1'b0;
                        end
                        else
                        begin
                            progress_next = '0;
                            disp_next     = 16'd0;
                            homed_next    = 1'b1;
                            mode_next     = MODE_IDLE;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                    end
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            remaining_reg <= '0;
            rem_mod5_reg  <= 3'd0;
            tick_reg      <= 8'd0;
            phase_reg     <= 1'b0;
            pulse_reg     <= 1'b0;
            progress_reg  <= '0;
            forward_reg   <= 1'b0;
            disp_reg      <= 16'd0;
        end
        else if (fire)
        begin
            mode_reg      <= mode_next;
            remaining_reg <= remaining_next;
            rem_mod5_reg  <= rem_mod5_next;
            tick_reg      <= tick_next;
            phase_reg     <= phase_next;
            pulse_reg     <= pulse_next;
            progress_reg  <= progress_next;
            forward_reg   <= forward_next;
            disp_reg      <= disp_next;
        end
    end

    // result of this item, taken from the updated state
    assign result.pulse         = pulse_next;
    assign result.dir_level     = !forward_next;
    assign result.enable_n      = (mode_next == MODE_IDLE);
    assign result.display_count = disp_next;
    assign result.busy_res      = (mode_next != MODE_IDLE);
    assign result.homed         = homed_next;

endmodule

`default_nettype wire

/* src/smhs_out_stage.sv */
// result register: holds one result transaction until the sink takes it
`default_nettype none

module smhs_out_stage
    import smhs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire result_t               result,
    output logic                       space,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    logic    valid_reg;
    result_t result_reg;

    assign space    = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (space)
        begin
            valid_reg <= load;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    // pack from the lowest bit up
    assign m_tdata = {3'd0,
                      result_reg.homed,
                      result_reg.busy_res,
                      result_reg.display_count,
                      result_reg.enable_n,
                      result_reg.dir_level,
                      result_reg.pulse};

endmodule

`default_nettype wire
